@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define RHSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen outside reset
`define RHSM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hw/rtl/rhsm_pkg.sv @@
// types and constants of the rolling hash string matcher
package rhsm_pkg;

  localparam int PatternMax = 64;
  localparam int OffsetBits = 32;
  localparam int HashW      = 32;
  localparam int HashShift  = 7;
  localparam int PtrW       = $clog2(PatternMax);
  localparam int LenW       = $clog2(PatternMax + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2
  } cmd_e;

  typedef enum logic {
    F_IDLE,
    F_EXEC
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_CHECK,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic [OffsetBits-1:0] offset;
    logic [PtrW-1:0]       start;
    logic [LenW-1:0]       len;
  } job_t;

  typedef struct packed {
    logic            en;
    logic [PtrW-1:0] addr;
    logic [7:0]      data;
  } ram_wr_t;

  typedef struct packed {
    logic            busy;
    logic [PtrW-1:0] pat_addr;
    logic [PtrW-1:0] win_addr;
  } back_rd_t;

endpackage

@@ hw/rtl/rhsm_ram.sv @@
// generic single write port ram with registered read
module rhsm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/rhsm_fifo.sv @@
// two entry queue of verification jobs between front and back
`include "assert_macros.svh"
module rhsm_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rhsm_pkg::job_t push_job_i,
  input  logic          pop_i,
  output logic          valid_o,
  output rhsm_pkg::job_t job_o
);
  import rhsm_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  assign valid_o = cnt_q != 2'd0;
  assign job_o   = mem_q[rd_q];

  `RHSM_ASSERT_NEVER(a_no_push_full, push_i && cnt_q == 2'd2 && !pop_i, "job queue overflow")

endmodule

@@ hw/rtl/rhsm_front.sv @@
// front end: takes words, keeps hashes and window pointer, queues hash hits
module rhsm_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                cmd_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      end_of_text_i,
  input  logic                      back_idle_i,
  input  logic [7:0]                win_rdata_i,
  output logic [rhsm_pkg::PtrW-1:0] win_raddr_o,
  output rhsm_pkg::ram_wr_t         pat_wr_o,
  output rhsm_pkg::ram_wr_t         win_wr_o,
  output logic                      job_push_o,
  output rhsm_pkg::job_t            job_o
);
  import rhsm_pkg::*;

  front_state_e          state_q, state_d;
  cmd_e                  cmd_q;
  logic [7:0]            byte_q;
  logic                  last_q;
  logic [LenW-1:0]       len_q, len_d, fill_q, fill_d;
  logic [HashW-1:0]      ph_q, ph_d, lf_q, lf_d, wh_q, wh_d;
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic [PtrW-1:0]       ptr_q, ptr_d, ptr_next;
  logic [HashW-1:0]      prod, roll, shift_in;
  logic                  full, accept;

  assign in_stall_o  = !(state_q == F_IDLE && back_idle_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign win_raddr_o = ptr_q;

  assign full     = fill_q == len_q;
  assign prod     = HashW'(win_rdata_i) * lf_q;
  assign roll     = ((wh_q - prod) << HashShift) + HashW'(byte_q);
  assign shift_in = (wh_q << HashShift) + HashW'(byte_q);
  assign ptr_next = (LenW'(ptr_q) == len_q - LenW'(1)) ? '0 : ptr_q + PtrW'(1);

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    fill_d     = fill_q;
    ph_d       = ph_q;
    lf_d       = lf_q;
    wh_d       = wh_q;
    pos_d      = pos_q;
    ptr_d      = ptr_q;
    pat_wr_o   = '{en: 1'b0, addr: len_q[PtrW-1:0], data: byte_q};
    win_wr_o   = '{en: 1'b0, addr: ptr_q, data: byte_q};
    job_push_o = 1'b0;
    job_o      = '{offset: pos_q - OffsetBits'(len_q) + OffsetBits'(1),
                   start: ptr_next, len: len_q};
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_EXEC;
        end
      end
      F_EXEC: begin
        state_d = F_IDLE;
        case (cmd_q)
          CMD_CLEAR: begin
            len_d  = '0;
            ph_d   = '0;
            lf_d   = HashW'(1);
            wh_d   = '0;
            fill_d = '0;
            pos_d  = '0;
            ptr_d  = '0;
          end
          CMD_PATTERN: begin
            if (len_q < LenW'(PatternMax)) begin
              pat_wr_o.en = 1'b1;
              if (len_q != '0) begin
                lf_d = lf_q << HashShift;
              end
              ph_d  = (ph_q << HashShift) + HashW'(byte_q);
              len_d = len_q + LenW'(1);
            end
            wh_d   = '0;
            fill_d = '0;
            pos_d  = '0;
            ptr_d  = '0;
          end
          CMD_TEXT: begin
            if (len_q != '0) begin
              win_wr_o.en = 1'b1;
              ptr_d       = ptr_next;
              wh_d        = full ? roll : shift_in;
              fill_d      = full ? fill_q : fill_q + LenW'(1);
              // hash hit on a full window goes to the back end for checking
              job_push_o  = (fill_d == len_q) && (wh_d == ph_q);
            end
            if (last_q) begin
              wh_d   = '0;
              fill_d = '0;
              pos_d  = '0;
              ptr_d  = '0;
            end else begin
              pos_d = pos_q + OffsetBits'(1);
            end
          end
          default: begin
          end
        endcase
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      len_q   <= '0;
      fill_q  <= '0;
      ph_q    <= '0;
      lf_q    <= HashW'(1);
      wh_q    <= '0;
      pos_q   <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      fill_q  <= fill_d;
      ph_q    <= ph_d;
      lf_q    <= lf_d;
      wh_q    <= wh_d;
      pos_q   <= pos_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(cmd_i);
      byte_q <= data_byte_i;
      last_q <= end_of_text_i;
    end
  end

endmodule

@@ hw/rtl/rhsm_back.sv @@
// back end: compares a hit window with the pattern byte by byte
`include "assert_macros.svh"
module rhsm_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  input  rhsm_pkg::job_t                    job_i,
  output logic                              job_pop_o,
  input  logic [7:0]                        pat_rdata_i,
  input  logic [7:0]                        win_rdata_i,
  output rhsm_pkg::back_rd_t                rd_o,
  output logic                              idle_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rhsm_pkg::OffsetBits-1:0]   match_offset_o
);
  import rhsm_pkg::*;

  back_state_e     state_q, state_d;
  job_t            job_q;
  logic [PtrW-1:0] idx_q, idx_d, wptr_q, wptr_d;
  logic            load;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    wptr_d    = wptr_q;
    job_pop_o = 1'b0;
    load      = 1'b0;
    rd_o      = '{busy: 1'b0, pat_addr: idx_q, win_addr: wptr_q};
    case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          load      = 1'b1;
          idx_d     = '0;
          wptr_d    = job_i.start;
          state_d   = B_READ;
        end
      end
      B_READ: begin
        rd_o.busy = 1'b1;
        state_d   = B_CHECK;
      end
      B_CHECK: begin
        rd_o.busy = 1'b1;
        if (pat_rdata_i != win_rdata_i) begin
          state_d = B_IDLE;
        end else if (LenW'(idx_q) == job_q.len - LenW'(1)) begin
          state_d = B_OUT;
        end else begin
          idx_d   = idx_q + PtrW'(1);
          wptr_d  = (LenW'(wptr_q) == job_q.len - LenW'(1)) ? '0 : wptr_q + PtrW'(1);
          state_d = B_READ;
        end
      end
      B_OUT: begin
        if (!out_stall_i) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      idx_q   <= '0;
      wptr_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      wptr_q  <= wptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
  end

  assign idle_o         = state_q == B_IDLE;
  assign out_valid_o    = state_q == B_OUT;
  assign match_offset_o = job_q.offset;

  `RHSM_ASSERT(a_out_len, state_q == B_OUT |-> job_q.len != '0, "match with empty pattern")

endmodule

@@ hw/rtl/rolling_hash_string_matcher.sv @@
// String matcher: rolling base-128 hash over a byte stream, hits checked byte by byte.
// The front end takes a word only while it and the back end are idle and no job is queued,
// then does a hash update that reads the oldest window byte from the window ram before it
// takes the next word. A hash hit queues a job for the back end, which reads pattern and
// window rams byte by byte; new words wait until it is done and any result word is taken.
`include "assert_macros.svh"
module rolling_hash_string_matcher (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      cmd_i,
  input  logic [7:0]                      data_byte_i,
  input  logic                            end_of_text_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rhsm_pkg::OffsetBits-1:0] match_offset_o
);
  import rhsm_pkg::*;

  ram_wr_t         pat_wr, win_wr;
  back_rd_t        back_rd;
  job_t            push_job, pop_job;
  logic            job_push, job_pop, job_valid, back_idle;
  logic [PtrW-1:0] front_raddr, win_raddr;
  logic [7:0]      pat_rdata, win_rdata;

  rhsm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .back_idle_i   (back_idle && !job_valid),
    .win_rdata_i   (win_rdata),
    .win_raddr_o   (front_raddr),
    .pat_wr_o      (pat_wr),
    .win_wr_o      (win_wr),
    .job_push_o    (job_push),
    .job_o         (push_job)
  );

  rhsm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_push),
    .push_job_i (push_job),
    .pop_i      (job_pop),
    .valid_o    (job_valid),
    .job_o      (pop_job)
  );

  rhsm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (pop_job),
    .job_pop_o      (job_pop),
    .pat_rdata_i    (pat_rdata),
    .win_rdata_i    (win_rdata),
    .rd_o           (back_rd),
    .idle_o         (back_idle),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .match_offset_o (match_offset_o)
  );

  assign win_raddr = back_rd.busy ? back_rd.win_addr : front_raddr;

  rhsm_ram #(.Width(8), .Depth(PatternMax)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_wr.en),
    .waddr_i (pat_wr.addr),
    .wdata_i (pat_wr.data),
    .raddr_i (back_rd.pat_addr),
    .rdata_o (pat_rdata)
  );

  rhsm_ram #(.Width(8), .Depth(PatternMax)) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_wr.en),
    .waddr_i (win_wr.addr),
    .wdata_i (win_wr.data),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  `RHSM_ASSERT(a_out_blocks_in, out_valid_o |-> in_stall_o, "word taken while result pending")

endmodule

@@ sim/rolling_hash_string_matcher_tb.sv @@
// testbench for the rolling hash string matcher: random byte streams checked against a predictor
`timescale 1ns / 1ps
module rolling_hash_string_matcher_tb;
  import rhsm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         PatCap     = PatternMax;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       eot;
    int         phase;
    logic       hold;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] cmd_i = CMD_CLEAR;
  logic [7:0] data_byte_i = 8'd0;
  logic end_of_text_i = 1'b0;
  logic in_hold = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [OffsetBits-1:0] match_offset_o;

  word_t pending_words[$];
  logic [OffsetBits-1:0] expected_offsets[$];
  int  drv_phase = 0;
  int  hold_left = 0;
  bit  failed = 0;
  int  idle_pct[4] = '{0, 51, 0, 35};
  int  stall_pct[4] = '{0, 0, 51, 35};

  // predictor state
  logic [7:0]            pat_bytes[PatCap];
  logic [7:0]            win_bytes[PatCap];
  int unsigned           pat_len;
  logic [31:0]           pat_hash, lead_factor, win_hash;
  logic [OffsetBits-1:0] text_pos;
  int unsigned           win_fill;

  rolling_hash_string_matcher DUT (.*);

  always #5 clk_i = ~clk_i;

  task automatic restart_text();
    win_hash = '0;
    win_fill = 0;
    text_pos = '0;
  endtask

  task automatic clear_matcher();
    pat_len = 0;
    pat_hash = '0;
    lead_factor = 32'd1;
    restart_text();
  endtask

  task automatic predict_offset(input logic [1:0] cmd, input logic [7:0] b, input logic eot);
    logic [7:0] oldest;
    bit same;
    if (cmd == CMD_CLEAR) begin
      clear_matcher();
    end else if (cmd == CMD_PATTERN) begin
      if (pat_len < PatCap) begin
        pat_bytes[pat_len] = b;
        if (pat_len > 0) lead_factor = lead_factor * 32'd128;
        pat_hash = (pat_hash << HashShift) + {24'd0, b};
        pat_len++;
      end
      restart_text();
    end else if (cmd == CMD_TEXT) begin
      if (pat_len > 0) begin
        if (win_fill < pat_len) begin
          win_bytes[win_fill] = b;
          win_fill++;
          win_hash = (win_hash << HashShift) + {24'd0, b};
        end else begin
          oldest = win_bytes[0];
          for (int i = 0; i + 1 < pat_len; i++) win_bytes[i] = win_bytes[i + 1];
          win_bytes[pat_len - 1] = b;
          win_hash = ((win_hash - {24'd0, oldest} * lead_factor) << HashShift) + {24'd0, b};
        end
        if (win_fill == pat_len && win_hash == pat_hash) begin
          same = 1;
          for (int i = 0; i < pat_len; i++) if (win_bytes[i] != pat_bytes[i]) same = 0;
          if (same) expected_offsets.push_back(text_pos - OffsetBits'(pat_len - 1));
        end
      end
      if (eot) restart_text();
      else text_pos = text_pos + 1'b1;
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_offset(cmd_i, data_byte_i, end_of_text_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() > 0 &&
            $urandom_range(99) >= idle_pct[pending_words[0].phase]) begin
          w = pending_words.pop_front();
          drv_phase <= w.phase;
          cmd_i <= w.cmd;
          data_byte_i <= w.data;
          end_of_text_i <= w.eot;
          in_hold <= w.hold;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off triggered by each marked word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
    end else if (in_valid_i && !in_stall_o && in_hold) begin
      hold_left <= 600;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct[drv_phase]);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic [OffsetBits-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_offsets.size() == 0) begin
        $display("%0t: unexpected match word, expected none, actual offset %0d",
                 $time, match_offset_o);
        failed = 1;
      end else begin
        want = expected_offsets.pop_front();
        if (match_offset_o !== want) begin
          $display("%0t: match_offset mismatch, expected %0d, actual %0d",
                   $time, want, match_offset_o);
          failed = 1;
        end
      end
    end
  end

  task automatic add_word(input logic [1:0] cmd, input logic [7:0] b, input logic eot,
                          input int phase, input logic hold = 1'b0);
    word_t w;
    w.cmd = cmd;
    w.data = b;
    w.eot = eot;
    w.phase = phase;
    w.hold = hold;
    pending_words.push_back(w);
  endtask

  // one well-formed run: pattern over a two-byte alphabet, then text that often contains it
  task automatic add_sequence(input int phase, input bit with_hold);
    logic [7:0] alpha[2];
    logic [7:0] pat[$];
    int plen, tlen, r;
    alpha[0] = 8'($urandom);
    alpha[1] = 8'($urandom);
    r = $urandom_range(99);
    plen = (r < 70) ? $urandom_range(1, 4) : (r < 95) ? $urandom_range(5, 10)
         : (r < 98) ? PatCap : PatCap + 2;
    if ($urandom_range(9) != 0) add_word(CMD_CLEAR, 8'($urandom), 1'($urandom), phase);
    pat.delete();
    for (int i = 0; i < plen; i++) begin
      pat.push_back(alpha[$urandom_range(1)]);
      add_word(CMD_PATTERN, pat[i], 1'($urandom), phase);
    end
    tlen = (plen > 10) ? PatCap + 10 : $urandom_range(3, 40);
    for (int i = 0; i < tlen; i++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        add_word(CMD_UNUSED, 8'($urandom), 1'($urandom), phase);
      end else if (r < 5) begin
        add_word(CMD_TEXT, 8'($urandom), 1'b0, phase);
      end else if (r < 20 && plen <= 10) begin
        foreach (pat[k]) add_word(CMD_TEXT, pat[k], 1'b0, phase, with_hold && k == 0);
      end else begin
        add_word(CMD_TEXT, alpha[$urandom_range(1)], 1'b0, phase);
      end
    end
    if (plen > 10) foreach (pat[k]) if (k < PatCap) add_word(CMD_TEXT, pat[k], 1'b0, phase);
    add_word(CMD_TEXT, alpha[$urandom_range(1)], 1'b1, phase);
    if ($urandom_range(7) == 0) begin
      add_word(CMD_PATTERN, alpha[0], 1'b0, phase);
      for (int i = 0; i < 6; i++) add_word(CMD_TEXT, alpha[$urandom_range(1)], i == 5, phase);
    end
  endtask

  initial begin
    int start;
    clear_matcher();
    // empty pattern, then two-byte pattern with two hits
    add_word(CMD_CLEAR, 8'h00, 1'b0, 0);
    add_word(CMD_TEXT, 8'h00, 1'b0, 0);
    add_word(CMD_TEXT, 8'hff, 1'b1, 0);
    add_word(CMD_PATTERN, 8'h00, 1'b0, 0);
    add_word(CMD_PATTERN, 8'hff, 1'b0, 0);
    add_word(CMD_TEXT, 8'h00, 1'b0, 0);
    add_word(CMD_TEXT, 8'hff, 1'b0, 0);
    add_word(CMD_UNUSED, 8'hff, 1'b1, 0);
    add_word(CMD_TEXT, 8'h00, 1'b0, 0);
    add_word(CMD_TEXT, 8'hff, 1'b1, 0);
    // short text
    add_word(CMD_TEXT, 8'h00, 1'b1, 0);
    // pattern byte in the middle of a text
    add_word(CMD_TEXT, 8'h00, 1'b0, 0);
    add_word(CMD_PATTERN, 8'h00, 1'b1, 0);
    add_word(CMD_TEXT, 8'h00, 1'b0, 0);
    add_word(CMD_TEXT, 8'hff, 1'b0, 0);
    add_word(CMD_TEXT, 8'h00, 1'b0, 0);
    add_word(CMD_TEXT, 8'h00, 1'b1, 0);
    for (int ph = 0; ph < 4; ph++) begin
      start = pending_words.size();
      while (pending_words.size() - start < 250) add_sequence(ph, ph == 0);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_words.size() == 0 && !in_valid_i);
    wait (expected_offsets.size() == 0);
    repeat (300) @(posedge clk_i);
    if (!failed && expected_offsets.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/rhsm_pkg.sv
hw/rtl/rhsm_ram.sv
hw/rtl/rhsm_fifo.sv
hw/rtl/rhsm_front.sv
hw/rtl/rhsm_back.sv
hw/rtl/rolling_hash_string_matcher.sv
sim/rolling_hash_string_matcher_tb.sv
